/* rtl/core/sawb_pkg.sv */
// ----------------------------------------------------------------------------
// sawb_pkg
// Shared types, widths and constants of the stop-and-wait backoff sender.
// ----------------------------------------------------------------------------
`default_nettype none

package sawb_pkg;

  // Field widths.
  localparam int unsigned SeqW     = 32;
  localparam int unsigned SlotW    = 16;
  localparam int unsigned IdW      = 32;
  localparam int unsigned DrawW    = 10;
  localparam int unsigned WaitW    = 26;
  localparam int unsigned AttW     = 4;
  localparam int unsigned TotW     = 32;
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  // Register reset values and defaults.
  localparam logic [SlotW-1:0] SlotReset       = 16'd10;
  localparam logic [IdW-1:0]   StationReset    = 32'd0;
  localparam int unsigned      MaxTriesDefault = 10;

  // The backoff window stops growing at this exponent.
  localparam logic [AttW-1:0] ExpCap = 4'd10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSlotTime  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgStationId = 1'b1;

  // Item kinds.
  localparam logic FuncBegin   = 1'b0;
  localparam logic FuncOutcome = 1'b1;

  typedef enum logic [1:0] {
    ActTransmit = 2'd0,
    ActAckWait  = 2'd1,
    ActRetry    = 2'd2,
    ActFailed   = 2'd3
  } sawb_action_e;

  typedef struct packed {
    logic             func;
    logic [SeqW-1:0]  frame_seq;
    logic             got_response;
    logic             response_is_noise;
    logic [SeqW-1:0]  response_seq;
    logic [IdW-1:0]   response_source;
    logic [DrawW-1:0] random_draw;
  } sawb_item_t;

  typedef struct packed {
    sawb_action_e     action;
    logic [WaitW-1:0] wait_ms;
    logic [AttW-1:0]  attempt_number;
    logic [TotW-1:0]  total_sent;
    logic [AttW-1:0]  max_per_frame;
  } sawb_result_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_time_ms;
    logic [IdW-1:0]   station_id;
  } sawb_cfg_t;

  // Mask of the backoff window, 2^exp - 1, limited to the draw width.
  function automatic logic [DrawW-1:0] backoff_mask(input logic [AttW-1:0] exp);
    logic [DrawW-1:0] ones;
    ones = '1;
    return ~(ones << exp);
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sawb_cfg_regs.sv */
// ----------------------------------------------------------------------------
// sawb_cfg_regs
// Configuration registers: slot time and station id.
// ----------------------------------------------------------------------------
`default_nettype none

module sawb_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [sawb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [sawb_pkg::CfgDataW-1:0]  cfg_data_i,
  output sawb_pkg::sawb_cfg_t                 cfg_o
);

  logic [sawb_pkg::SlotW-1:0] slot_q;
  logic [sawb_pkg::IdW-1:0]   station_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q    <= sawb_pkg::SlotReset;
      station_q <= sawb_pkg::StationReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sawb_pkg::CfgSlotTime:  slot_q    <= cfg_data_i[sawb_pkg::SlotW-1:0];
        sawb_pkg::CfgStationId: station_q <= cfg_data_i[sawb_pkg::IdW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.slot_time_ms = slot_q;
  assign cfg_o.station_id   = station_q;

endmodule

`default_nettype wire

/* rtl/core/sawb_in_reg.sv */
// ----------------------------------------------------------------------------
// sawb_in_reg
// Input register: holds one accepted word until the engine consumes it.
// ----------------------------------------------------------------------------
`default_nettype none

module sawb_in_reg (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire sawb_pkg::sawb_item_t item_i,
  input  wire logic                 take_i,
  output logic                      valid_o,
  output sawb_pkg::sawb_item_t      item_o
);

  logic                 valid_q;
  sawb_pkg::sawb_item_t item_q;

  // The slot frees up when the held word is consumed in this cycle.
  assign in_ready_o = !valid_q || take_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

/* rtl/core/sawb_engine.sv */
// ----------------------------------------------------------------------------
// sawb_engine
// Frame state and the per-word decision: ack check, backoff and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module sawb_engine #(
  parameter int unsigned MaxTries = sawb_pkg::MaxTriesDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 advance_i,
  input  wire sawb_pkg::sawb_item_t item_i,
  input  wire sawb_pkg::sawb_cfg_t  cfg_i,
  output sawb_pkg::sawb_result_t    result_o
);

  localparam int unsigned AttW  = sawb_pkg::AttW;
  localparam int unsigned TotW  = sawb_pkg::TotW;
  localparam int unsigned WaitW = sawb_pkg::WaitW;
  localparam logic [AttW-1:0] MaxTriesC = AttW'(MaxTries);
  localparam logic [AttW-1:0] OneAtt    = AttW'(1);

  logic [sawb_pkg::SeqW-1:0] seq_q, seq_d;
  logic [AttW-1:0]           att_q, att_d;
  logic [TotW-1:0]           tot_q, tot_d;
  logic [AttW-1:0]           max_q, max_d;

  logic                       is_ack;
  logic [AttW-1:0]            exp;
  logic [sawb_pkg::DrawW-1:0] masked_draw;
  logic [WaitW-1:0]           backoff;
  logic [TotW-1:0]            tot_inc;
  logic [AttW-1:0]            max_upd;

  assign is_ack = item_i.got_response && !item_i.response_is_noise &&
                  (item_i.response_seq == seq_q) &&
                  (item_i.response_source == cfg_i.station_id);

  assign exp         = (att_q < sawb_pkg::ExpCap) ? att_q : sawb_pkg::ExpCap;
  assign masked_draw = item_i.random_draw & sawb_pkg::backoff_mask(exp);
  assign backoff     = WaitW'(masked_draw) * WaitW'(cfg_i.slot_time_ms);
  assign tot_inc     = (tot_q == '1) ? tot_q : tot_q + TotW'(1);
  assign max_upd     = (att_q > max_q) ? att_q : max_q;

  always_comb begin
    seq_d = seq_q;
    att_d = att_q;
    tot_d = tot_q;
    max_d = max_q;
    result_o.action         = sawb_pkg::ActFailed;
    result_o.wait_ms        = '0;
    result_o.attempt_number = '0;
    priority if (item_i.func == sawb_pkg::FuncBegin) begin
      seq_d = item_i.frame_seq;
      att_d = OneAtt;
      tot_d = tot_inc;
      result_o.action         = sawb_pkg::ActTransmit;
      result_o.attempt_number = OneAtt;
    end else if (att_q == '0) begin
      // Outcome with no frame open: report failure and change nothing.
      result_o.action = sawb_pkg::ActFailed;
    end else if (is_ack) begin
      att_d = '0;
      max_d = max_upd;
      result_o.action         = sawb_pkg::ActAckWait;
      result_o.wait_ms        = WaitW'(cfg_i.slot_time_ms);
      result_o.attempt_number = att_q;
    end else if (att_q < MaxTriesC) begin
      att_d = att_q + OneAtt;
      tot_d = tot_inc;
      result_o.action         = sawb_pkg::ActRetry;
      result_o.wait_ms        = backoff;
      result_o.attempt_number = att_q + OneAtt;
    end else begin
      att_d = '0;
      max_d = max_upd;
      result_o.action         = sawb_pkg::ActFailed;
      result_o.wait_ms        = backoff;
      result_o.attempt_number = att_q;
    end
    result_o.total_sent    = tot_d;
    result_o.max_per_frame = max_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
      att_q <= '0;
      tot_q <= '0;
      max_q <= '0;
    end else if (advance_i) begin
      seq_q <= seq_d;
      att_q <= att_d;
      tot_q <= tot_d;
      max_q <= max_d;
    end
  end

  a_att_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    att_q <= MaxTriesC) else $error("attempt count beyond the try limit");

  a_max_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q <= MaxTriesC) else $error("per-frame maximum beyond the try limit");

  a_tot_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> tot_q >= $past(tot_q)) else $error("total transmissions went down");

  a_begin_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && (item_i.func == sawb_pkg::FuncBegin) |=> att_q == OneAtt)
    else $error("a new frame did not start at one transmission");

endmodule

`default_nettype wire

/* rtl/core/sawb_out_reg.sv */
// ----------------------------------------------------------------------------
// sawb_out_reg
// Result register with its valid flag; frees itself when the word is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sawb_out_reg (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   load_i,
  input  wire sawb_pkg::sawb_result_t result_i,
  output logic                        can_load_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output sawb_pkg::sawb_result_t      result_o
);

  logic                   valid_q;
  sawb_pkg::sawb_result_t result_q;

  assign can_load_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

/* rtl/core/stop_and_wait_backoff_sender.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_backoff_sender
// Sender side of a slotted stop-and-wait scheme with truncated binary
// exponential backoff.
// ----------------------------------------------------------------------------
// An accepted word is held in the input register, then its result is captured
// in the result register, from which it is taken on the result channel.
// Throughput: one word per cycle unless the result channel stalls; the
// decision logic between the two registers is one pass with a 10x16 multiply.
// Reset (rst_ni low, asynchronous) clears all frame state and counters, sets
// slot time to 10 ms and station id to 0, and empties both registers.
`default_nettype none

module stop_and_wait_backoff_sender #(
  parameter int unsigned MaxTries = sawb_pkg::MaxTriesDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  // Input word channel.
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic                          func_i,
  input  wire logic [sawb_pkg::SeqW-1:0]     frame_seq_i,
  input  wire logic                          got_response_i,
  input  wire logic                          response_is_noise_i,
  input  wire logic [sawb_pkg::SeqW-1:0]     response_seq_i,
  input  wire logic [sawb_pkg::IdW-1:0]      response_source_i,
  input  wire logic [sawb_pkg::DrawW-1:0]    random_draw_i,

  // Result word channel.
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         action_o,
  output logic [sawb_pkg::WaitW-1:0]         wait_ms_o,
  output logic [sawb_pkg::AttW-1:0]          attempt_number_o,
  output logic [sawb_pkg::TotW-1:0]          total_sent_o,
  output logic [sawb_pkg::AttW-1:0]          max_per_frame_o,

  // Configuration write channel.
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [sawb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [sawb_pkg::CfgDataW-1:0] cfg_data_i
);

  sawb_pkg::sawb_item_t   in_item;
  sawb_pkg::sawb_item_t   held_item;
  sawb_pkg::sawb_result_t next_result;
  sawb_pkg::sawb_result_t out_result;
  sawb_pkg::sawb_cfg_t    cfg;
  logic                   held_valid;
  logic                   out_can_load;
  logic                   advance;

  // Always writable; user must write only while the block idles, unchecked.
  assign cfg_ready_o = 1'b1;

  sawb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign in_item.func              = func_i;
  assign in_item.frame_seq         = frame_seq_i;
  assign in_item.got_response      = got_response_i;
  assign in_item.response_is_noise = response_is_noise_i;
  assign in_item.response_seq      = response_seq_i;
  assign in_item.response_source   = response_source_i;
  assign in_item.random_draw       = random_draw_i;

  // The held word moves on whenever the result register is free or being
  // emptied in the same cycle, so the pipe runs without bubbles.
  assign advance = held_valid && out_can_load;

  sawb_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  // Frame state updates at the same edge that captures the result, so the
  // following word always sees the state left by the one before it.
  sawb_engine #(
    .MaxTries (MaxTries)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (held_item),
    .cfg_i     (cfg),
    .result_o  (next_result)
  );

  sawb_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .result_i    (next_result),
    .can_load_o  (out_can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (out_result)
  );

  assign action_o         = out_result.action;
  assign wait_ms_o        = out_result.wait_ms;
  assign attempt_number_o = out_result.attempt_number;
  assign total_sent_o     = out_result.total_sent;
  assign max_per_frame_o  = out_result.max_per_frame;

endmodule

`default_nettype wire
